>>> rtl/core/motor_kalman_observer_macros.svh
// Assertion helpers shared by the observer RTL.
// Both sample on aclk and are off while aresetn is low.
`ifndef MOTOR_KALMAN_OBSERVER_MACROS_SVH
`define MOTOR_KALMAN_OBSERVER_MACROS_SVH

// same-cycle implication
`define MKO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MKO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mko_pkg.sv
package mko_pkg;

    localparam int DW     = 48;   // Q24.24 word
    localparam int AW     = 52;   // dot-product accumulator
    localparam int MW     = 50;   // unsigned product magnitude
    localparam int CFG_N  = 8;
    localparam int ADDR_W = 6;
    localparam int IN_W   = 240;
    localparam int OUT_W  = 192;

    localparam logic signed [DW-1:0] MAX_V         = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DW-1:0] MIN_V         = 48'sh8000_0000_0000;
    localparam logic signed [DW-1:0] Q_ONE         = 48'sd16777216;
    localparam logic signed [DW-1:0] SAMPLE_PERIOD = 48'sd16777;
    localparam logic signed [DW-1:0] DIAG_INIT     = 48'sd1677721600;

    // register map (index = paddr / 8)
    localparam logic [2:0] CFG_SPEED_DECAY   = 3'd0;
    localparam logic [2:0] CFG_SPEED_FROM_I  = 3'd1;
    localparam logic [2:0] CFG_SPEED_FROM_D  = 3'd2;
    localparam logic [2:0] CFG_I_FROM_SPEED  = 3'd3;
    localparam logic [2:0] CFG_I_DECAY       = 3'd4;
    localparam logic [2:0] CFG_I_FROM_V      = 3'd5;
    localparam logic [2:0] CFG_PROC_NOISE    = 3'd6;
    localparam logic [2:0] CFG_MEAS_NOISE    = 3'd7;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } res_t;

    // sign a magnitude back and clamp
    function automatic res_t apply_sign(input logic [MW-1:0] m, input logic neg);
        res_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (m > {{(MW-DW){1'b0}}, MIN_V}) begin
                r.val = MIN_V;
                r.sat = 1'b1;
            end else begin
                r.val = ~m[DW-1:0] + 1'b1;
            end
        end else begin
            if (m > {{(MW-DW){1'b0}}, MAX_V}) begin
                r.val = MAX_V;
                r.sat = 1'b1;
            end else begin
                r.val = m[DW-1:0];
            end
        end
        return r;
    endfunction

    // transition matrix entries that are not structurally zero
    function automatic logic fnz(input logic [1:0] r, input logic [1:0] c);
        logic nz;
        case ({r, c})
            4'h0, 4'h1, 4'h5, 4'h6, 4'h7, 4'h9, 4'hA, 4'hF: nz = 1'b1;
            default: nz = 1'b0;
        endcase
        return nz;
    endfunction

    function automatic logic signed [AW-1:0] sx(input logic signed [DW-1:0] v);
        return {{(AW-DW){v[DW-1]}}, v};
    endfunction

endpackage

>>> rtl/core/mko_fmul.sv
// Q24.24 multiply on one 24x24 multiplier, four partial products.
module mko_fmul import mko_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] a,
    input  logic signed [DW-1:0] b,
    output logic                 done,
    output res_t                 res
);

    logic          busy_reg;
    logic          done_reg;
    logic [2:0]    step_reg;
    logic          neg_reg;
    logic          hisat_reg;
    logic [DW-1:0] ua_reg;
    logic [DW-1:0] ub_reg;
    logic [DW-1:0] prod_reg;
    logic [MW-1:0] acc_reg;
    logic [23:0]   ma;
    logic [23:0]   mb;

    // step 0: a0*b0, 1: a1*b0, 2: a0*b1, 3: a1*b1
    assign ma = step_reg[0] ? ua_reg[47:24] : ua_reg[23:0];
    assign mb = step_reg[1] ? ub_reg[47:24] : ub_reg[23:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                step_reg  <= 3'd0;
                neg_reg   <= a[DW-1] ^ b[DW-1];
                ua_reg    <= a[DW-1] ? (~a + 1'b1) : a;
                ub_reg    <= b[DW-1] ? (~b + 1'b1) : b;
                acc_reg   <= '0;
                hisat_reg <= 1'b0;
            end else if (busy_reg) begin
                if (step_reg != 3'd4) begin
                    prod_reg <= {24'd0, ma} * {24'd0, mb};
                end
                case (step_reg)
                    3'd1: acc_reg <= ({2'b00, prod_reg} + 50'd8388608) >> 24;
                    3'd2, 3'd3: acc_reg <= acc_reg + {2'b00, prod_reg};
                    3'd4: begin
                        if (prod_reg[47:24] != 24'd0) begin
                            hisat_reg <= 1'b1;
                        end else begin
                            acc_reg <= acc_reg + {2'b00, prod_reg[23:0], 24'd0};
                        end
                    end
                    default: ;
                endcase
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    assign done = done_reg;

    always_comb begin
        if (hisat_reg) begin
            res.val = neg_reg ? MIN_V : MAX_V;
            res.sat = 1'b1;
        end else begin
            res = apply_sign(acc_reg, neg_reg);
        end
    end

endmodule

>>> rtl/core/mko_recip.sv
// 2^48 / |s| rounded, restoring division, one quotient bit a cycle.
module mko_recip import mko_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] s,
    output logic                 done,
    output res_t                 res
);

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic          neg_reg;
    logic          zero_reg;
    logic [DW-1:0] div_reg;
    logic [DW:0]   num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW:0]   q_reg;
    logic [DW-1:0] mag_s;
    logic [DW:0]   trial;
    logic          fits;

    assign mag_s = s[DW-1] ? (~s + 1'b1) : s;
    assign trial = {rem_reg, num_reg[DW]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                zero_reg <= (s == '0);
                neg_reg  <= s[DW-1];
                div_reg  <= mag_s;
                num_reg  <= {1'b1, {DW{1'b0}}} + {2'b00, mag_s[DW-1:1]};
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= 6'(DW + 1);
                busy_reg <= (s != '0);
                done_reg <= (s == '0);
            end else if (busy_reg) begin
                rem_reg <= fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
                q_reg   <= {q_reg[DW-1:0], fits};
                num_reg <= {num_reg[DW-1:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    always_comb begin
        if (zero_reg) begin
            res.val = MAX_V;
            res.sat = 1'b1;
        end else begin
            res = apply_sign({1'b0, q_reg}, neg_reg);
        end
    end

endmodule

>>> rtl/core/motor_kalman_observer.sv
// Four-state Kalman observer (angle, speed, current, load disturbance), Q24.24.
// Update beat: each structurally nonzero product runs on the single shared 24x24
// multiplier, and the gain reciprocal on the divider, which answers at once when the
// innovation variance is zero. Restart beat: the start state is loaded and handed
// straight to the output register. One beat in flight at a time.
// Reset (aresetn low, synchronous): estimate zero, covariance diag 100, registers
`include "motor_kalman_observer_macros.svh"

// at their defaults (unit decays, noise R = 1.0), no result pending.
module motor_kalman_observer import mko_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    // measured_angle, drive_voltage, start_angle, start_speed, start_current
    input  logic [IN_W-1:0]   s_tdata,
    // mode (1 = restart)
    input  logic [0:0]        s_tuser,
    // result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    // est_angle, est_speed, est_current, est_disturbance
    output logic [OUT_W-1:0]  m_tdata,
    // saturated
    output logic [0:0]        m_tuser,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TERM  = 3'd1;  // pick next product term
    localparam logic [2:0] ST_WAIT  = 3'd2;  // multiplier busy
    localparam logic [2:0] ST_STORE = 3'd3;  // add addend, saturate, write back
    localparam logic [2:0] ST_RECIP = 3'd4;
    localparam logic [2:0] ST_RWAIT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;  // hand estimate to output register

    // update phases, in execution order
    localparam logic [3:0] PH_XPRED = 4'd0;   // x = F x
    localparam logic [3:0] PH_XVOLT = 4'd1;   // x2 += b u
    localparam logic [3:0] PH_FP    = 4'd2;   // T = F P
    localparam logic [3:0] PH_PFT   = 4'd3;   // P = T F'
    localparam logic [3:0] PH_ADDQ  = 4'd4;   // P22 += q
    localparam logic [3:0] PH_S     = 4'd5;   // S = P00 + R
    localparam logic [3:0] PH_GAIN  = 4'd6;   // K = P(:,0) / S
    localparam logic [3:0] PH_INNOV = 4'd7;   // z - x0
    localparam logic [3:0] PH_EST   = 4'd8;   // x += K innov
    localparam logic [3:0] PH_MCOL  = 4'd9;   // K <- e - K (first column of I - K H)
    localparam logic [3:0] PH_MP    = 4'd10;  // P = M P, in place, rows 3..0

    logic [2:0] state_reg, state_next;
    logic [3:0] ph_reg, ph_after;
    logic [1:0] i_reg, j_reg, k_reg, ri, fr;

    logic signed [DW-1:0] cfg_reg  [CFG_N];
    logic signed [DW-1:0] est_reg  [4];
    logic signed [DW-1:0] xv_reg   [4];
    logic signed [DW-1:0] kv_reg   [4];
    logic signed [DW-1:0] p_reg    [16];
    logic signed [DW-1:0] t_reg    [16];
    logic signed [DW-1:0] z_reg, u_reg, s_reg, inv_reg, innov_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 sat_reg;

    logic [OUT_W-1:0] out_reg;
    logic             out_sat_reg;
    logic             m_valid_reg;

    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic [3:0]           p_addr;
    logic signed [DW-1:0] p_rd, t_rd, fval, op_a, op_b, tot_v;
    logic signed [AW-1:0] add_v, tot;
    logic                 tot_sat, act, lp_ij, lp_i, last;
    logic                 mul_start, mul_done, rcp_start, rcp_done;
    res_t                 mul_res, rcp_res;
    logic                 in_acc, out_load;

    // ---------------------------------------------------------------
    // register port: 64-bit data, register i at byte 8*i
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[5:3];
    // noise registers keep bit 47 clear, so sign extension reads back unsigned
    assign prdata  = {{(64-DW){cfg_reg[cfg_idx][DW-1]}}, cfg_reg[cfg_idx]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < CFG_N; n++) begin
                cfg_reg[n] <= '0;
            end
            cfg_reg[CFG_SPEED_DECAY] <= Q_ONE;
            cfg_reg[CFG_I_DECAY]     <= Q_ONE;
            cfg_reg[CFG_MEAS_NOISE]  <= Q_ONE;
        end else if (cfg_wr) begin
            if (cfg_idx == CFG_PROC_NOISE || cfg_idx == CFG_MEAS_NOISE) begin
                cfg_reg[cfg_idx] <= {1'b0, pwdata[DW-2:0]};
            end else begin
                cfg_reg[cfg_idx] <= pwdata[DW-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // operand routing
    // ---------------------------------------------------------------
    assign ri = (ph_reg == PH_MP) ? ~i_reg : i_reg;
    assign fr = (ph_reg == PH_PFT) ? j_reg : ri;

    // F row fr, column k
    always_comb begin
        case ({fr, k_reg})
            4'h0:    fval = Q_ONE;
            4'h1:    fval = SAMPLE_PERIOD;
            4'h5:    fval = cfg_reg[CFG_SPEED_DECAY];
            4'h6:    fval = cfg_reg[CFG_SPEED_FROM_I];
            4'h7:    fval = cfg_reg[CFG_SPEED_FROM_D];
            4'h9:    fval = cfg_reg[CFG_I_FROM_SPEED];
            4'hA:    fval = cfg_reg[CFG_I_DECAY];
            4'hF:    fval = Q_ONE;
            default: fval = '0;
        endcase
    end

    // single covariance read port; store cycles read the addend / write target
    always_comb begin
        p_addr = 4'd0;
        if (state_reg == ST_STORE) begin
            unique case (ph_reg) inside
                PH_PFT, PH_MP: p_addr = {ri, j_reg};
                PH_ADDQ:       p_addr = 4'hA;
                default:       p_addr = 4'd0;
            endcase
        end else begin
            unique case (ph_reg) inside
                PH_FP:   p_addr = {k_reg, j_reg};
                PH_GAIN: p_addr = {ri, 2'd0};
                PH_MP:   p_addr = {2'd0, j_reg};
                default: p_addr = 4'd0;
            endcase
        end
    end

    assign p_rd = p_reg[p_addr];
    assign t_rd = t_reg[{ri, k_reg}];

    always_comb begin
        op_a = '0;
        op_b = '0;
        act  = 1'b0;
        unique case (ph_reg) inside
            PH_XPRED: begin
                op_a = fval;
                op_b = est_reg[k_reg];
                act  = fnz(ri, k_reg);
            end
            PH_XVOLT: begin
                op_a = cfg_reg[CFG_I_FROM_V];
                op_b = u_reg;
                act  = (k_reg == 2'd0);
            end
            PH_FP: begin
                op_a = fval;
                op_b = p_rd;
                act  = fnz(ri, k_reg);
            end
            PH_PFT: begin
                op_a = t_rd;
                op_b = fval;
                act  = fnz(j_reg, k_reg);
            end
            PH_GAIN: begin
                op_a = p_rd;
                op_b = inv_reg;
                act  = (k_reg == 2'd0);
            end
            PH_EST: begin
                op_a = kv_reg[ri];
                op_b = innov_reg;
                act  = (k_reg == 2'd0);
            end
            PH_MP: begin
                op_a = kv_reg[ri];
                op_b = p_rd;
                act  = (k_reg == 2'd0);
            end
            default: ;
        endcase
    end

    // addend joined to the product sum before the single saturation
    always_comb begin
        unique case (ph_reg) inside
            PH_XVOLT: add_v = sx(xv_reg[2]);
            PH_ADDQ:  add_v = sx(p_rd) + sx(cfg_reg[CFG_PROC_NOISE]);
            PH_S:     add_v = sx(p_rd) + sx(cfg_reg[CFG_MEAS_NOISE]);
            PH_INNOV: add_v = sx(z_reg) - sx(xv_reg[0]);
            PH_EST:   add_v = sx(xv_reg[ri]);
            PH_MCOL:  add_v = ((ri == 2'd0) ? sx(Q_ONE) : '0) - sx(kv_reg[ri]);
            PH_MP:    add_v = (ri != 2'd0) ? sx(p_rd) : '0;
            default:  add_v = '0;
        endcase
    end

    assign tot = acc_reg + add_v;

    always_comb begin
        tot_sat = 1'b0;
        if (tot > sx(MAX_V)) begin
            tot_v   = MAX_V;
            tot_sat = 1'b1;
        end else if (tot < sx(MIN_V)) begin
            tot_v   = MIN_V;
            tot_sat = 1'b1;
        end else begin
            tot_v = tot[DW-1:0];
        end
    end

    // loop shape of each phase
    assign lp_ij = (ph_reg == PH_FP) || (ph_reg == PH_PFT) || (ph_reg == PH_MP);
    assign lp_i  = (ph_reg == PH_XPRED) || (ph_reg == PH_GAIN) ||
                   (ph_reg == PH_EST) || (ph_reg == PH_MCOL);
    assign last  = lp_ij ? (i_reg == 2'd3 && j_reg == 2'd3) :
                   lp_i  ? (i_reg == 2'd3) : 1'b1;

    always_comb begin
        unique case (ph_reg)
            PH_XPRED: ph_after = PH_XVOLT;
            PH_XVOLT: ph_after = PH_FP;
            PH_FP:    ph_after = PH_PFT;
            PH_PFT:   ph_after = PH_ADDQ;
            PH_ADDQ:  ph_after = PH_S;
            PH_S:     ph_after = PH_GAIN;
            PH_GAIN:  ph_after = PH_INNOV;
            PH_INNOV: ph_after = PH_EST;
            PH_EST:   ph_after = PH_MCOL;
            PH_MCOL:  ph_after = PH_MP;
            default:  ph_after = PH_XPRED;
        endcase
    end

    // ---------------------------------------------------------------
    // shared arithmetic units
    // ---------------------------------------------------------------
    assign mul_start = (state_reg == ST_TERM) && act;
    assign rcp_start = (state_reg == ST_RECIP);

    mko_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .res     (mul_res)
    );

    mko_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rcp_start),
        .s       (s_reg),
        .done    (rcp_done),
        .res     (rcp_res)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = s_tuser[0] ? ST_DONE : ST_TERM;
                end
            end
            ST_TERM: begin
                if (act) begin
                    state_next = ST_WAIT;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_STORE;
                end
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = (k_reg == 2'd3) ? ST_STORE : ST_TERM;
                end
            end
            ST_STORE: begin
                if (last && ph_reg == PH_S) begin
                    state_next = ST_RECIP;
                end else if (last && ph_reg == PH_MP) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_TERM;
                end
            end
            ST_RECIP: state_next = ST_RWAIT;
            ST_RWAIT: begin
                if (rcp_done) begin
                    state_next = ST_TERM;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ph_reg      <= PH_XPRED;
            i_reg       <= 2'd0;
            j_reg       <= 2'd0;
            k_reg       <= 2'd0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int n = 0; n < 4; n++) begin
                est_reg[n] <= '0;
            end
            for (int n = 0; n < 16; n++) begin
                p_reg[n] <= (n % 5 == 0) ? DIAG_INIT : '0;
            end
        end else begin
            state_reg <= state_next;

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                out_reg     <= {est_reg[3], est_reg[2], est_reg[1], est_reg[0]};
                out_sat_reg <= sat_reg;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        sat_reg <= 1'b0;
                        acc_reg <= '0;
                        ph_reg  <= PH_XPRED;
                        i_reg   <= 2'd0;
                        j_reg   <= 2'd0;
                        k_reg   <= 2'd0;
                        z_reg   <= s_tdata[47:0];
                        u_reg   <= s_tdata[95:48];
                        if (s_tuser[0]) begin
                            est_reg[0] <= s_tdata[143:96];
                            est_reg[1] <= s_tdata[191:144];
                            est_reg[2] <= s_tdata[239:192];
                            est_reg[3] <= '0;
                            for (int n = 0; n < 16; n++) begin
                                p_reg[n] <= (n % 5 == 0) ? DIAG_INIT : '0;
                            end
                        end
                    end
                end
                ST_TERM: begin
                    if (!act && k_reg != 2'd3) begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        acc_reg <= acc_reg + sx(mul_res.val);
                        sat_reg <= sat_reg | mul_res.sat;
                        if (k_reg != 2'd3) begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                end
                ST_STORE: begin
                    sat_reg <= sat_reg | tot_sat;
                    acc_reg <= '0;
                    k_reg   <= 2'd0;
                    unique case (ph_reg) inside
                        PH_XPRED:              xv_reg[ri]  <= tot_v;
                        PH_XVOLT:              xv_reg[2]   <= tot_v;
                        PH_FP:                 t_reg[{ri, j_reg}] <= tot_v;
                        PH_PFT, PH_ADDQ, PH_MP: p_reg[p_addr] <= tot_v;
                        PH_S:                  s_reg       <= tot_v;
                        PH_GAIN, PH_MCOL:      kv_reg[ri]  <= tot_v;
                        PH_INNOV:              innov_reg   <= tot_v;
                        PH_EST:                est_reg[ri] <= tot_v;
                        default: ;
                    endcase
                    if (!last) begin
                        if (lp_ij) begin
                            j_reg <= j_reg + 2'd1;
                            if (j_reg == 2'd3) begin
                                i_reg <= i_reg + 2'd1;
                            end
                        end else begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end else begin
                        i_reg  <= 2'd0;
                        j_reg  <= 2'd0;
                        ph_reg <= ph_after;
                    end
                end
                ST_RWAIT: begin
                    if (rcp_done) begin
                        inv_reg <= rcp_res.val;
                        sat_reg <= sat_reg | rcp_res.sat;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = out_sat_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `MKO_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `MKO_ASSERT_IMP(a_mul_done_in_wait, mul_done, state_reg == ST_WAIT, "stray multiply result")
    `MKO_ASSERT_IMP(a_rcp_done_in_rwait, rcp_done, state_reg == ST_RWAIT, "stray reciprocal")
    `MKO_ASSERT_NXT(a_result_loaded, out_load, m_tvalid && state_reg == ST_IDLE, "result lost")

endmodule
